// ===== rtl/bdq_pkg.sv =====
// Package for the bounded deque: word widths, opcodes, status codes and
// the operation code that drives the cell chain. No dependencies.
`timescale 1ns / 1ps

package bdq_pkg;

    localparam int DEFAULT_CAPACITY    = 16;
    localparam int DEFAULT_VALUE_WIDTH = 32;
    localparam int DEFAULT_COUNT_W     = 5;

    localparam int WORD_W   = 32;
    localparam int OPCODE_W = 3;
    localparam int STATUS_W = 2;

    typedef enum logic [OPCODE_W-1:0] {
        OP_APPEND   = 3'd0,
        OP_PUSH_HEAD = 3'd1,
        OP_POP_TAIL = 3'd2,
        OP_POP_HEAD = 3'd3,
        OP_DELETE   = 3'd4
    } t_opcode;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_EMPTY    = 2'd1,
        ST_NOTFOUND = 2'd2,
        ST_FULL     = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        CELL_HOLD      = 3'd0,
        CELL_LOAD_TAIL = 3'd1,
        CELL_SHIFT_IN  = 3'd2,
        CELL_DROP_TAIL = 3'd3,
        CELL_SHIFT_OUT = 3'd4,
        CELL_DELETE    = 3'd5
    } t_cell_op;

endpackage

// ===== rtl/bdq_req_if.sv =====
// Request channel of the bounded deque: valid/ready plus opcode and operand.
// Depends on bdq_pkg.
`timescale 1ns / 1ps

interface bdq_req_if;
    import bdq_pkg::*;

    logic                       valid;
    logic                       ready;
    logic [OPCODE_W-1:0]        opcode;
    logic signed [WORD_W-1:0]   operand_value;

    modport source (output valid, output opcode, output operand_value, input ready);
    modport sink   (input valid, input opcode, input operand_value, output ready);
endinterface

// ===== rtl/bdq_rsp_if.sv =====
// Response channel of the bounded deque: valid/ready plus status, removed
// value and entry count. Depends on bdq_pkg.
`timescale 1ns / 1ps

interface bdq_rsp_if #(
    parameter int ENTRY_COUNT_W = bdq_pkg::DEFAULT_COUNT_W
);
    import bdq_pkg::*;

    logic                       valid;
    logic                       ready;
    logic [STATUS_W-1:0]        status;
    logic signed [WORD_W-1:0]   removed_value;
    logic [ENTRY_COUNT_W-1:0]   entry_count;

    modport source (output valid, output status, output removed_value, output entry_count,
                    input ready);
    modport sink   (input valid, input status, input removed_value, input entry_count,
                    output ready);
endinterface

// ===== rtl/bdq_cell.sv =====
// One slot of the deque chain: holds a value and its valid bit, shifts with
// its neighbors, and ripples the first-match and tail-value chains.
// Depends on bdq_pkg.
`timescale 1ns / 1ps

module bdq_cell #(
    parameter int VALUE_WIDTH = bdq_pkg::DEFAULT_VALUE_WIDTH
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  bdq_pkg::t_cell_op      i_op,
    input  logic [VALUE_WIDTH-1:0] i_operand,
    input  logic [VALUE_WIDTH-1:0] i_left_val,
    input  logic                   i_left_valid,
    input  logic [VALUE_WIDTH-1:0] i_right_val,
    input  logic                   i_right_valid,
    input  logic                   i_seen,
    input  logic [VALUE_WIDTH-1:0] i_tail,
    output logic                   o_seen,
    output logic [VALUE_WIDTH-1:0] o_tail,
    output logic [VALUE_WIDTH-1:0] o_val,
    output logic                   o_valid
);
    import bdq_pkg::*;

    logic [VALUE_WIDTH-1:0] r_val, n_val;
    logic                   r_valid, n_valid;
    logic                   w_hit;

    assign w_hit   = r_valid && (r_val == i_operand);
    assign o_seen  = i_seen || w_hit;
    assign o_tail  = (r_valid && !i_right_valid) ? r_val : i_tail;
    assign o_val   = r_val;
    assign o_valid = r_valid;

    always_comb begin
        n_val   = r_val;
        n_valid = r_valid;
        unique case (i_op)
            CELL_LOAD_TAIL: begin
                if (!r_valid && i_left_valid) begin
                    n_val   = i_operand;
                    n_valid = 1'b1;
                end
            end
            CELL_SHIFT_IN: begin
                n_val   = i_left_val;
                n_valid = i_left_valid;
            end
            CELL_DROP_TAIL: begin
                n_valid = i_right_valid;
            end
            CELL_SHIFT_OUT: begin
                n_val   = i_right_val;
                n_valid = i_right_valid;
            end
            CELL_DELETE: begin
                // this slot and every slot after the first match close the gap
                if (o_seen) begin
                    n_val   = i_right_val;
                    n_valid = i_right_valid;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
    end

endmodule

// ===== rtl/bounded_deque_with_value_delete.sv =====
// Top level of the bounded deque with value delete: request decode, the
// chain of bdq_cell slots, entry count and registered response.
// Depends on bdq_pkg, bdq_req_if, bdq_rsp_if and bdq_cell.
//
//  port    | dir | word
//  --------+-----+---------------------------------------------
//  i_req   | in  | opcode, operand_value
//  o_rsp   | out | status, removed_value, entry_count
//
// The match and tail chains ripple combinationally through all CAPACITY
// cells, so each request acts on the cells in the cycle it is accepted.
// Reset clears the count and the cell valid bits at once; no clearing pass.
// A request is taken whenever the response register is empty or is being
// read in the same cycle; a stalled response holds only the request side.
`timescale 1ns / 1ps

module bounded_deque_with_value_delete #(
    parameter int CAPACITY    = bdq_pkg::DEFAULT_CAPACITY,
    parameter int VALUE_WIDTH = bdq_pkg::DEFAULT_VALUE_WIDTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    bdq_req_if.sink     i_req,
    bdq_rsp_if.source   o_rsp
);
    import bdq_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic [CNT_W-1:0]        r_count, n_count;
    logic                    r_out_valid;
    t_status                 r_status, w_status;
    logic [WORD_W-1:0]       r_removed, w_removed_word;
    logic [VALUE_WIDTH-1:0]  w_removed;
    logic [VALUE_WIDTH-1:0]  w_operand;
    t_opcode                 w_op;
    t_cell_op                w_cell_op, w_dec_op;
    logic                    w_acc, w_full, w_empty;

    logic [VALUE_WIDTH-1:0]  w_val  [CAPACITY];
    logic [CAPACITY-1:0]     w_valid;
    logic [CAPACITY:0]       w_seen;
    logic [VALUE_WIDTH-1:0]  w_tail [CAPACITY+1];

    assign i_req.ready = !r_out_valid || o_rsp.ready;
    assign w_acc       = i_req.valid && i_req.ready;
    assign w_op        = t_opcode'(i_req.opcode);
    assign w_full      = (r_count == CNT_W'(CAPACITY));
    assign w_empty     = (r_count == '0);

    // operand fitted to the store width, sign-extended when the store is wider
    if (VALUE_WIDTH == WORD_W) begin : g_fit_equal
        assign w_operand      = i_req.operand_value;
        assign w_removed_word = w_removed;
    end else if (VALUE_WIDTH < WORD_W) begin : g_fit_narrow
        assign w_operand      = i_req.operand_value[VALUE_WIDTH-1:0];
        assign w_removed_word = {{(WORD_W-VALUE_WIDTH){w_removed[VALUE_WIDTH-1]}}, w_removed};
    end else begin : g_fit_wide
        assign w_operand      = {{(VALUE_WIDTH-WORD_W){i_req.operand_value[WORD_W-1]}},
                                 i_req.operand_value};
        assign w_removed_word = w_removed[WORD_W-1:0];
    end

    assign w_seen[0] = 1'b0;
    assign w_tail[0] = '0;

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [VALUE_WIDTH-1:0] w_lv, w_rv;
        logic                   w_lvalid, w_rvalid;

        if (g == 0) begin : g_head
            assign w_lv     = w_operand;
            assign w_lvalid = 1'b1;
        end else begin : g_mid_l
            assign w_lv     = w_val[g-1];
            assign w_lvalid = w_valid[g-1];
        end

        if (g == CAPACITY - 1) begin : g_last
            assign w_rv     = '0;
            assign w_rvalid = 1'b0;
        end else begin : g_mid_r
            assign w_rv     = w_val[g+1];
            assign w_rvalid = w_valid[g+1];
        end

        bdq_cell #(
            .VALUE_WIDTH (VALUE_WIDTH)
        ) u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_op          (w_cell_op),
            .i_operand     (w_operand),
            .i_left_val    (w_lv),
            .i_left_valid  (w_lvalid),
            .i_right_val   (w_rv),
            .i_right_valid (w_rvalid),
            .i_seen        (w_seen[g]),
            .i_tail        (w_tail[g]),
            .o_seen        (w_seen[g+1]),
            .o_tail        (w_tail[g+1]),
            .o_val         (w_val[g]),
            .o_valid       (w_valid[g])
        );
    end

    always_comb begin
        n_count   = r_count;
        w_status  = ST_OK;
        w_removed = '0;
        w_dec_op  = CELL_HOLD;
        unique case (w_op)
            OP_APPEND: begin
                if (w_full) begin
                    w_status = ST_FULL;
                end else begin
                    w_dec_op = CELL_LOAD_TAIL;
                    n_count  = r_count + CNT_W'(1);
                end
            end
            OP_PUSH_HEAD: begin
                if (w_full) begin
                    w_status = ST_FULL;
                end else begin
                    w_dec_op = CELL_SHIFT_IN;
                    n_count  = r_count + CNT_W'(1);
                end
            end
            OP_POP_TAIL: begin
                if (w_empty) begin
                    w_status = ST_EMPTY;
                end else begin
                    w_dec_op  = CELL_DROP_TAIL;
                    w_removed = w_tail[CAPACITY];
                    n_count   = r_count - CNT_W'(1);
                end
            end
            OP_POP_HEAD: begin
                if (w_empty) begin
                    w_status = ST_EMPTY;
                end else begin
                    w_dec_op  = CELL_SHIFT_OUT;
                    w_removed = w_val[0];
                    n_count   = r_count - CNT_W'(1);
                end
            end
            OP_DELETE: begin
                w_dec_op = CELL_DELETE;
                if (w_seen[CAPACITY]) begin
                    n_count = r_count - CNT_W'(1);
                end else begin
                    w_status = ST_NOTFOUND;
                end
            end
            default: ;
        endcase
    end

    assign w_cell_op = w_acc ? w_dec_op : CELL_HOLD;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_acc) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_status  <= w_status;
            r_removed <= w_removed_word;
        end
    end

    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.status        = r_status;
    assign o_rsp.removed_value = r_removed;
    assign o_rsp.entry_count   = r_count;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    a_valid_matches_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(w_valid) == int'(r_count))
        else $error("cell valid bits disagree with entry count");

    a_valid_packed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((w_valid + CAPACITY'(1)) & w_valid) == '0)
        else $error("valid cells not packed toward the head");

    a_empty_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_status == ST_EMPTY) |-> (r_count == '0))
        else $error("empty status with entries held");

    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_status == ST_FULL) |-> (r_count == CNT_W'(CAPACITY)))
        else $error("full status with room left");

endmodule
